// ===== src/pfe_pkg.sv =====
// shared types, codes and constants for the postfix expression evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package pfe_pkg;

  localparam int STACK_DEPTH_DEF = 128;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } pfe_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } pfe_out_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DELIM   = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_POW
  } alu_op_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic acc_digit;
    logic clr_lit;
    logic delim_err;
    logic under_err;
    logic push_lit;
    logic rd_top;
    logic rd_second;
    logic load_t;
    logic alu_start;
    logic alu_wb;
    logic load_out;
  } pfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_delim;
    logic is_op;
    logic last;
    logic in_lit;
    logic err_set;
    logic sp_lt2;
    logic sp_zero;
    logic alu_done;
    logic out_busy;
  } pfe_stat_t;

endpackage

`default_nettype wire

// ===== src/postfix_expression_evaluator.sv =====
// postfix expression evaluator, one character per beat, result on the last one
// digits, delimiters and ignored codes are taken in the decode state; an operator
// reads both operands, then runs the alu, which does / and ^ one bit a step;
// the last character then passes push, check and read states before the result loads
// one character in flight at a time; a held result stalls only the next last character
// rst is synchronous: stack empty, accumulator and error cleared, no result held
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire pfe_pkg::pfe_in_t item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output pfe_pkg::pfe_out_t     result
);
  import pfe_pkg::*;

  pfe_cmd_t  cmd;
  pfe_stat_t stat;

  pfe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pfe_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire

// ===== src/pfe_alu.sv =====
// arithmetic unit: add, sub and mul in one step, restoring divide and
// square-and-multiply power over 32 / 31 steps; uses pfe_pkg
`default_nettype none

module pfe_alu (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire pfe_pkg::alu_op_t op,
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  output logic                  done,
  output logic [31:0]           res,
  output logic                  dz
);
  import pfe_pkg::*;

  logic          busy;
  alu_op_t       mode;
  logic [4:0]    cnt;
  logic [31:0]   acc_q;
  logic [31:0]   base_r;
  logic [31:0]   opnd;
  logic          neg;

  logic [31:0] a_mag, b_mag;
  logic [32:0] sh, diff;
  logic        ge;
  logic [31:0] quo_next, rem_next;
  logic [31:0] prod, sq, acc_next;

  assign a_mag = a[31] ? (32'd0 - a) : a;
  assign b_mag = b[31] ? (32'd0 - b) : b;

  // one restoring divide step: remainder in base_r, quotient in acc_q
  assign sh       = {base_r, acc_q[31]};
  assign ge       = sh >= {1'b0, opnd};
  assign diff     = sh - {1'b0, opnd};
  assign rem_next = ge ? diff[31:0] : sh[31:0];
  assign quo_next = {acc_q[30:0], ge};

  // one power step: acc_q accumulates, base_r is squared
  assign prod     = acc_q * base_r;
  assign sq       = base_r * base_r;
  assign acc_next = opnd[0] ? prod : acc_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dz   <= 1'b0;
        mode <= op;
        case (op)
          ALU_ADD: begin
            res  <= a + b;
            done <= 1'b1;
          end
          ALU_SUB: begin
            res  <= a - b;
            done <= 1'b1;
          end
          ALU_MUL: begin
            res  <= a * b;
            done <= 1'b1;
          end
          ALU_DIV: begin
            if (b == 32'd0) begin
              res  <= 32'd0;
              dz   <= 1'b1;
              done <= 1'b1;
            end else begin
              acc_q  <= a_mag;
              base_r <= 32'd0;
              opnd   <= b_mag;
              neg    <= a[31] ^ b[31];
              cnt    <= 5'd31;
              busy   <= 1'b1;
            end
          end
          ALU_POW: begin
            if (b[31]) begin
              // negative exponent, truncated result
              done <= 1'b1;
              if (a == 32'd1) begin
                res <= 32'd1;
              end else if (a == 32'hFFFF_FFFF) begin
                res <= b[0] ? 32'hFFFF_FFFF : 32'd1;
              end else if (a == 32'd0) begin
                res <= 32'd0;
                dz  <= 1'b1;
              end else begin
                res <= 32'd0;
              end
            end else begin
              acc_q  <= 32'd1;
              base_r <= a;
              opnd   <= b;
              cnt    <= 5'd30;
              busy   <= 1'b1;
            end
          end
          default: begin
            res  <= 32'd0;
            done <= 1'b1;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (mode == ALU_DIV) begin
          base_r <= rem_next;
          acc_q  <= quo_next;
          if (cnt == 5'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
            res  <= neg ? (32'd0 - quo_next) : quo_next;
          end
        end else begin
          acc_q  <= acc_next;
          base_r <= sq;
          opnd   <= {1'b0, opnd[31:1]};
          if (cnt == 5'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
            res  <= acc_next;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pfe_dp.sv =====
// datapath: value stack memory, literal accumulator, error code, output register
// uses pfe_pkg and pfe_alu
`default_nettype none

module pfe_dp #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_stat_t     stat,
  input  wire pfe_pkg::pfe_in_t  item,
  output pfe_pkg::pfe_out_t      result,
  output logic                   result_valid,
  input  wire logic              result_ready
);
  import pfe_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  logic [31:0] mem [STACK_DEPTH];

  logic [7:0]     ch;
  logic           last;
  logic [SPW-1:0] sp;
  logic [31:0]    acc;
  logic           in_lit;
  logic [2:0]     err;
  logic [31:0]    rd_data;
  logic [31:0]    t_val;

  logic [SPW-1:0] sp_m1, sp_m2;
  logic [31:0]    acc_base, acc_next;
  logic           full, push_ok, wr_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [31:0]    wr_data;
  alu_op_t        alu_op;
  logic           alu_done, alu_dz;
  logic [31:0]    alu_res;

  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);
  assign full  = (sp == SP_FULL);

  // acc * 10 + digit; a fresh literal starts from zero
  assign acc_base = in_lit ? acc : 32'd0;
  assign acc_next = (acc_base << 3) + (acc_base << 1) + {28'd0, ch[3:0]};

  assign push_ok = cmd.push_lit && !full;
  assign wr_en   = push_ok || (cmd.alu_wb && !alu_dz);
  assign wr_addr = push_ok ? sp[AW-1:0] : sp_m2[AW-1:0];
  assign wr_data = push_ok ? acc : alu_res;
  assign rd_addr = cmd.rd_second ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

  always_comb begin
    case (ch)
      CH_PLUS:  alu_op = ALU_ADD;
      CH_MINUS: alu_op = ALU_SUB;
      CH_STAR:  alu_op = ALU_MUL;
      CH_SLASH: alu_op = ALU_DIV;
      default:  alu_op = ALU_POW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_top || cmd.rd_second) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch   <= item.char_code;
      last <= item.end_of_expr;
    end
    if (cmd.load_t) begin
      t_val <= rd_data;
    end
    if (cmd.load_out) begin
      result.value  <= (err == ST_OK) ? $signed(rd_data) : 32'sd0;
      result.status <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      acc          <= 32'd0;
      in_lit       <= 1'b0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.load_out) begin
        sp     <= '0;
        acc    <= 32'd0;
        in_lit <= 1'b0;
        err    <= ST_OK;
      end else begin
        if (cmd.acc_digit) begin
          acc    <= acc_next;
          in_lit <= 1'b1;
        end
        if (cmd.clr_lit) begin
          in_lit <= 1'b0;
        end
        if (cmd.delim_err) begin
          err <= ST_DELIM;
        end
        if (cmd.under_err) begin
          err <= ST_UNDER;
        end
        if (cmd.push_lit) begin
          if (full) begin
            err <= ST_OVER;
          end else begin
            sp <= sp + SPW'(1);
          end
        end
        if (cmd.alu_wb) begin
          if (alu_dz) begin
            err <= ST_DIVZERO;
          end else begin
            sp <= sp_m1;
          end
        end
      end
    end
  end

  pfe_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.alu_start),
    .op    (alu_op),
    .a     (rd_data),
    .b     (t_val),
    .done  (alu_done),
    .res   (alu_res),
    .dz    (alu_dz)
  );

  always_comb begin
    stat.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    stat.is_delim = (ch == CH_SPACE) || (ch == CH_COMMA);
    stat.is_op    = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) ||
                    (ch == CH_SLASH) || (ch == CH_CARET);
    stat.last     = last;
    stat.in_lit   = in_lit;
    stat.err_set  = (err != ST_OK);
    stat.sp_lt2   = (sp < SPW'(2));
    stat.sp_zero  = (sp == '0);
    stat.alu_done = alu_done;
    stat.out_busy = result_valid && !result_ready;
  end

endmodule

`default_nettype wire

// ===== src/pfe_ctrl.sv =====
// controller state machine: sequences decode, stack reads, alu and end of expression
// uses pfe_pkg
`default_nettype none

module pfe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t       cmd
);
  import pfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_S,
    S_EXEC,
    S_WAIT,
    S_FIN,
    S_FIN_CHK,
    S_FIN_RD
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = stat.last ? S_FIN : S_IDLE;
        if (!stat.err_set) begin
          if (stat.is_digit) begin
            cmd.acc_digit = 1'b1;
          end else if (stat.in_lit) begin
            cmd.clr_lit = 1'b1;
            if (stat.is_delim) begin
              cmd.push_lit = 1'b1;
            end else begin
              cmd.delim_err = 1'b1;
            end
          end else if (stat.is_op) begin
            if (stat.sp_lt2) begin
              cmd.under_err = 1'b1;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_RD_S;
            end
          end
        end
      end
      S_RD_S: begin
        cmd.load_t    = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        cmd.alu_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.alu_done) begin
          cmd.alu_wb = 1'b1;
          state_next = stat.last ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // a literal still open at the end is pushed first
        if (!stat.err_set && stat.in_lit) begin
          cmd.push_lit = 1'b1;
        end
        state_next = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        if (!stat.err_set && stat.sp_zero) begin
          cmd.under_err = 1'b1;
        end
        cmd.rd_top = 1'b1;
        state_next = S_FIN_RD;
      end
      S_FIN_RD: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfe_checker.sv =====
// port-level checks for the postfix expression evaluator, bound to the top level
// uses pfe_pkg
`default_nettype none

module pfe_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire pfe_pkg::pfe_in_t item,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire pfe_pkg::pfe_out_t result
);
  import pfe_pkg::*;

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status <= ST_DIVZERO))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> (result.value == 32'sd0))
    else $error("nonzero value with error status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result shown after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("result dropped or changed while stalled");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_ready) |=> (item_valid && $stable(item)))
    else $error("input beat dropped or changed while waiting");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
